// ----- sv/dma_pkg.sv -----
// ============================================================================
// dma_pkg
// Shared types and constants of the two-channel moving average with warm-up.
// ============================================================================
package dma_pkg;

    // Width of the samples-held field of a result.
    localparam int HELD_BITS = 5;

    // Sequencer states of the back end, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SUM   = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_back_state;

endpackage

// ----- sv/dma_if.sv -----
// ============================================================================
// dma_if
// Valid/ready channels for sample pairs and for filtered results.
// ============================================================================

// Channel carrying one left/right sample pair per request.
interface dma_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

// Channel carrying one pair of averages and the sample count per request.
interface dma_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     average_left;
    logic signed [SAMPLE_BITS-1:0]     average_right;
    logic [dma_pkg::HELD_BITS-1:0]     samples_held;

    modport source (output valid, output average_left, output average_right,
                    output samples_held, input ready);
    modport sink   (input valid, input average_left, input average_right,
                    input samples_held, output ready);
endinterface

// ----- sv/dma_front.sv -----
// ============================================================================
// dma_front
// Accepts sample pairs, tracks ring position and fill level, and tags each
// request with its slot, its fill state and the divisor it will need.
// ============================================================================
module dma_front #(
    parameter int  WINDOW    = 20,
    parameter int  SLOT_BITS = 5,
    parameter int  CNT_BITS  = 5,
    parameter type t_item    = logic
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dma_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_item    o_q_item
);

    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic [CNT_BITS-1:0]  r_fill, n_fill;
    logic                 ring_full;

    // A request is taken whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    assign ring_full = (r_fill == CNT_BITS'(WINDOW));

    // Next ring slot wraps at the window length; fill level saturates at it.
    always_comb begin
        n_slot = (r_slot == SLOT_BITS'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        n_fill = ring_full ? r_fill : r_fill + 1'b1;
    end

    // Tag the request for the back end.
    always_comb begin
        o_q_item.left  = i_in.sample_left;
        o_q_item.right = i_in.sample_right;
        o_q_item.slot  = r_slot;
        o_q_item.full  = ring_full;
        o_q_item.count = n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (o_q_push) begin
            r_slot <= n_slot;
            r_fill <= n_fill;
        end
    end

endmodule

// ----- sv/dma_queue.sv -----
// ============================================================================
// dma_queue
// Two-entry queue between the front end and the back end.
// ============================================================================
module dma_queue #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    // Storage is written only on a push.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/dma_div.sv -----
// ============================================================================
// dma_div
// Restoring divider, one quotient bit per cycle, signed dividend by a
// positive divisor, quotient truncated toward zero.
// ============================================================================
module dma_div #(
    parameter int DIV_BITS = 29,
    parameter int DEN_BITS = 5,
    parameter int OUT_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [DIV_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0]        i_divisor,
    output logic                       o_done,
    output logic signed [OUT_BITS-1:0] o_quotient
);

    localparam int STEP_BITS = $clog2(DIV_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [DEN_BITS-1:0]  r_den;
    logic [DEN_BITS-1:0]  r_rem, n_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic                 r_neg;
    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS-1:0]  diff;
    logic                 fits;
    logic [DIV_BITS-1:0]  magnitude;

    // Magnitude of the dividend; the most negative value maps onto itself.
    assign magnitude = i_dividend[DIV_BITS-1] ? DIV_BITS'(-i_dividend)
                                              : DIV_BITS'(i_dividend);

    // One restoring step: shift in the next dividend bit and try a subtract.
    // When the subtract fits, the difference is below the divisor, so its
    // low bits are the whole remainder.
    always_comb begin
        trial = {r_rem, r_quo[DIV_BITS-1]};
        diff  = trial[DEN_BITS-1:0] - r_den;
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? diff : trial[DEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= STEP_BITS'(DIV_BITS - 1);
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quo  <= magnitude;
            r_neg  <= i_dividend[DIV_BITS-1];
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            r_rem  <= n_rem;
            r_quo  <= {r_quo[DIV_BITS-2:0], fits};
        end
    end

    // Restore the sign; the quotient always fits the output field.
    assign o_quotient = r_neg ? -r_quo[OUT_BITS-1:0] : r_quo[OUT_BITS-1:0];
    assign o_done     = r_done;

endmodule

// ----- sv/dma_back.sv -----
// ============================================================================
// dma_back
// Ring memory, running sums, the two dividers and the result register.
// ============================================================================
module dma_back #(
    parameter int  WINDOW      = 20,
    parameter int  SAMPLE_BITS = 24,
    parameter int  CNT_BITS    = 5,
    parameter int  SUM_BITS    = 29,
    parameter type t_item      = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_item     i_q_head,
    output logic      o_q_pop,
    dma_out_if.source o_out
);

    import dma_pkg::*;

    localparam int RING_BITS = 2 * SAMPLE_BITS;

    t_back_state                   r_state, n_state;
    logic [RING_BITS-1:0]          r_ring [WINDOW];
    logic [RING_BITS-1:0]          r_old;
    t_item                         r_cur;
    logic signed [SUM_BITS-1:0]    r_sum_l, r_sum_r, n_sum_l, n_sum_r;
    logic signed [SAMPLE_BITS-1:0] old_l, old_r;
    logic signed [SAMPLE_BITS-1:0] quo_l, quo_r;
    logic                          done_l, done_r;
    logic                          div_start;
    logic                          out_free;
    logic                          out_load;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg_l, r_avg_r;
    logic [HELD_BITS-1:0]          r_held;

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer: take a request, update sums, divide, hand over the result.
    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_START;
            end
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (done_l && done_r) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring memory: the oldest pair is read out as the new pair replaces it.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_old                  <= r_ring[i_q_head.slot];
            r_ring[i_q_head.slot]  <= {i_q_head.left, i_q_head.right};
            r_cur                  <= i_q_head;
        end
    end

    assign old_l = r_old[RING_BITS-1:SAMPLE_BITS];
    assign old_r = r_old[SAMPLE_BITS-1:0];

    // Running sums: add the new sample, drop the oldest once the ring is full.
    always_comb begin
        n_sum_l = r_sum_l + SUM_BITS'(r_cur.left)
                - (r_cur.full ? SUM_BITS'(old_l) : SUM_BITS'(0));
        n_sum_r = r_sum_r + SUM_BITS'(r_cur.right)
                - (r_cur.full ? SUM_BITS'(old_r) : SUM_BITS'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else if (r_state == ST_SUM) begin
            r_sum_l <= n_sum_l;
            r_sum_r <= n_sum_r;
        end
    end

    // One divider per channel, running in lockstep.
    dma_div #(
        .DIV_BITS (SUM_BITS),
        .DEN_BITS (CNT_BITS),
        .OUT_BITS (SAMPLE_BITS)
    ) u_div_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum_l),
        .i_divisor  (r_cur.count),
        .o_done     (done_l),
        .o_quotient (quo_l)
    );

    dma_div #(
        .DIV_BITS (SUM_BITS),
        .DEN_BITS (CNT_BITS),
        .OUT_BITS (SAMPLE_BITS)
    ) u_div_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum_r),
        .i_divisor  (r_cur.count),
        .o_done     (done_r),
        .o_quotient (quo_r)
    );

    // Result register decouples the sequencer from the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_avg_l <= quo_l;
            r_avg_r <= quo_r;
            r_held  <= HELD_BITS'(r_cur.count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.average_left  = r_avg_l;
    assign o_out.average_right = r_avg_r;
    assign o_out.samples_held  = r_held;

endmodule

// ----- sv/dual_moving_average_warmup.sv -----
// ============================================================================
// dual_moving_average_warmup
// Two-channel moving average over the last WINDOW wheel speed samples, with
// a warm-up phase that averages over the samples held so far.
// ============================================================================
//
//   Channel   Direction  Handshake      Payload
//   i_in      sink       valid/ready    sample_left, sample_right
//   o_out     source     valid/ready    average_left, average_right,
//                                       samples_held
//
// In the back end each request is popped, added to the running sums and
// divided by the bit-serial dividers, which produce one quotient bit per
// cycle. The front end and a two-entry queue take up to two
// further requests while one is being worked on, and a finished result waits
// in its own register while the next one is computed. Reset is synchronous,
// active low, and clears the fill level, ring position and sums; no clearing
// pass is needed. A stalled consumer holds the back end only once a second
// result is ready to be handed over.
// ============================================================================
module dual_moving_average_warmup #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dma_in_if.sink    i_in,
    dma_out_if.source o_out
);

    localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);

    // Request as it travels from the front end to the back end.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [SLOT_BITS-1:0]          slot;
        logic                          full;
        logic [CNT_BITS-1:0]           count;
    } t_item;

    logic  q_push, q_pop, q_full, q_empty;
    t_item q_in, q_head;

    dma_front #(
        .WINDOW    (WINDOW),
        .SLOT_BITS (SLOT_BITS),
        .CNT_BITS  (CNT_BITS),
        .t_item    (t_item)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    dma_queue #(
        .t_item (t_item)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    dma_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_BITS    (CNT_BITS),
        .SUM_BITS    (SUM_BITS),
        .t_item      (t_item)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- sv/dma_checker.sv -----
// ============================================================================
// dma_checker
// Port-level checks of the moving average block, bound to its top level.
// ============================================================================
module dma_checker #(
    parameter int WINDOW = 20
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dma_pkg::HELD_BITS-1:0] i_samples_held
);

    import dma_pkg::*;

    localparam logic [HELD_BITS-1:0] FULL_HELD = HELD_BITS'(WINDOW);

    logic                 in_acc, out_acc;
    logic [2:0]           r_pend;
    logic                 r_seen;
    logic [HELD_BITS-1:0] r_last;
    logic [HELD_BITS-1:0] next_held;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_acc   = i_out_valid && i_out_ready;
    assign next_held = r_last + 1'b1;

    // Requests taken but not yet answered, and the last count delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_seen <= 1'b0;
            r_last <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, in_acc} - {2'b00, out_acc};
            if (out_acc) begin
                r_seen <= 1'b1;
                r_last <= i_samples_held;
            end
        end
    end

    // A result offered and not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // No result without a request waiting for it.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pend != 3'd0))
        else $error("result delivered without a pending request");

    // The sample count lies between one and the window length (checked for windows of at most 31).
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (WINDOW > 31) ||
                        ((i_samples_held != '0) && (i_samples_held <= FULL_HELD)))
        else $error("samples held out of range");

    // The count climbs by one per result until the window is full, then stays.
    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen |-> (i_samples_held == next_held) ||
                              ((i_samples_held == r_last) && (r_last == FULL_HELD)))
        else $error("samples held does not follow the warm-up sequence");

endmodule

bind dual_moving_average_warmup dma_checker #(
    .WINDOW (WINDOW)
) u_dma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_samples_held (o_out.samples_held)
);
